/* src/crc16fc_pkg.sv */
// shared types, constants and the crc step for the crc16 frame checker
package crc16fc_pkg;

  localparam int HDR_BYTES = 8;
  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] HDR_COUNT = COUNT_W'(HDR_BYTES);

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] MAGIC_RST = 8'hA3;
  localparam logic [7:0] VERSION_RST = 8'h01;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = CFG_IDX_W'(1);

  // queue between front and back
  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW = $clog2(MQ_DEPTH);

  // header offset classes, members 0..7 match the header offsets
  typedef enum logic [3:0] {
    FLD_MAGIC,
    FLD_VERSION,
    FLD_KIND,
    FLD_RSVD,
    FLD_LEN_LO,
    FLD_LEN_HI,
    FLD_CRC_LO,
    FLD_CRC_HI,
    FLD_PAYLOAD
  } field_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BAD_MAGIC    = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_CRC_MISMATCH = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    field_t             field;
    logic               magic_hit;
    logic               version_hit;
    logic [COUNT_W-1:0] total;
  } item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    status_t     status;
    logic [7:0]  message_type;
    logic [15:0] payload_length;
  } result_t;

  // one byte of reflected crc16, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/crc16fc_front.sv */
// front end: byte counter, offset classification and header compares
module crc16fc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  input  logic [7:0]                    magic_value,
  input  logic [7:0]                    version_value,
  input  logic                          q_full,
  output logic                          q_push,
  output crc16fc_pkg::item_t            q_item
);

  logic [crc16fc_pkg::COUNT_W-1:0] count_r;
  logic [crc16fc_pkg::COUNT_W-1:0] count_nxt;
  logic [crc16fc_pkg::COUNT_W-1:0] total;
  crc16fc_pkg::field_t             field;

  assign q_push = in_push & ~q_full;

  // saturating count of bytes including this one
  assign total = (count_r == crc16fc_pkg::COUNT_MAX) ? count_r
                                                     : count_r + 1'b1;

  always_comb begin
    if (count_r >= crc16fc_pkg::HDR_COUNT) begin
      field = crc16fc_pkg::FLD_PAYLOAD;
    end else begin
      field = crc16fc_pkg::field_t'({1'b0, count_r[2:0]});
    end
  end

  always_comb begin
    q_item.data        = in_data_byte;
    q_item.last        = in_last_byte;
    q_item.field       = field;
    q_item.magic_hit   = (in_data_byte == magic_value);
    q_item.version_hit = (in_data_byte == version_value);
    q_item.total       = total;
  end

  assign count_nxt = in_last_byte ? '0 : total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (q_push) begin
      count_r <= count_nxt;
    end
  end

endmodule

/* src/crc16fc_queue.sv */
// small queue of classified bytes between front and back
module crc16fc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  crc16fc_pkg::item_t  din,
  output logic                full,
  input  logic                pop,
  output crc16fc_pkg::item_t  dout,
  output logic                empty
);

  crc16fc_pkg::item_t               mem_r [crc16fc_pkg::MQ_DEPTH];
  logic [crc16fc_pkg::MQ_AW-1:0]    wr_ptr_r;
  logic [crc16fc_pkg::MQ_AW-1:0]    rd_ptr_r;
  logic [crc16fc_pkg::MQ_AW:0]      cnt_r;
  logic [crc16fc_pkg::MQ_AW:0]      cnt_nxt;

  assign full  = (cnt_r == (crc16fc_pkg::MQ_AW+1)'(crc16fc_pkg::MQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* src/crc16fc_back.sv */
// back end: crc, header capture, status and the result queue
module crc16fc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  crc16fc_pkg::item_t    item,
  output logic                  item_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output crc16fc_pkg::result_t  out_head
);

  logic [15:0] crc_r, crc_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic        version_ok_r, version_ok_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;

  crc16fc_pkg::status_t status;
  crc16fc_pkg::result_t res;

  // two-entry result queue
  crc16fc_pkg::result_t oq_r [2];
  logic                 oq_wr_r;
  logic                 oq_rd_r;
  logic [1:0]           oq_cnt_r;
  logic                 oq_take;

  assign oq_take  = out_pop & ~out_empty;
  assign item_pop = item_valid & ((oq_cnt_r != 2'd2) | oq_take);

  // header capture and crc update for this byte
  always_comb begin
    magic_ok_nxt   = magic_ok_r;
    version_ok_nxt = version_ok_r;
    kind_nxt       = kind_r;
    len_nxt        = len_r;
    rcrc_nxt       = rcrc_r;
    unique case (item.field)
      crc16fc_pkg::FLD_MAGIC:   magic_ok_nxt   = item.magic_hit;
      crc16fc_pkg::FLD_VERSION: version_ok_nxt = item.version_hit;
      crc16fc_pkg::FLD_KIND:    kind_nxt       = item.data;
      crc16fc_pkg::FLD_LEN_LO:  len_nxt        = {len_r[15:8], item.data};
      crc16fc_pkg::FLD_LEN_HI:  len_nxt        = {item.data, len_r[7:0]};
      crc16fc_pkg::FLD_CRC_LO:  rcrc_nxt       = {rcrc_r[15:8], item.data};
      crc16fc_pkg::FLD_CRC_HI:  rcrc_nxt       = {item.data, rcrc_r[7:0]};
      default: ;
    endcase
    if (item.field == crc16fc_pkg::FLD_CRC_LO || item.field == crc16fc_pkg::FLD_CRC_HI) begin
      crc_nxt = crc_r;
    end else begin
      crc_nxt = crc16fc_pkg::crc_byte(crc_r, item.data);
    end
  end

  // fail-fast checks, first failing one wins
  always_comb begin
    priority if (item.total < crc16fc_pkg::HDR_COUNT) begin
      status = crc16fc_pkg::ST_SHORT;
    end else if (!magic_ok_nxt) begin
      status = crc16fc_pkg::ST_BAD_MAGIC;
    end else if (!version_ok_nxt) begin
      status = crc16fc_pkg::ST_BAD_VERSION;
    end else if (({1'b0, len_nxt} + crc16fc_pkg::HDR_COUNT) != item.total) begin
      status = crc16fc_pkg::ST_LEN_MISMATCH;
    end else if (crc_nxt != rcrc_nxt) begin
      status = crc16fc_pkg::ST_CRC_MISMATCH;
    end else begin
      status = crc16fc_pkg::ST_OK;
    end
  end

  always_comb begin
    res.payload_valid = (item.field == crc16fc_pkg::FLD_PAYLOAD);
    res.payload_byte  = res.payload_valid ? item.data : 8'h00;
    res.frame_done    = item.last;
    res.status        = item.last ? status : crc16fc_pkg::ST_OK;
    res.message_type  = (item.last && status == crc16fc_pkg::ST_OK) ? kind_nxt : 8'h00;
    res.payload_length = (item.last && status != crc16fc_pkg::ST_SHORT) ? len_nxt : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= crc16fc_pkg::CRC_INIT;
      magic_ok_r   <= 1'b0;
      version_ok_r <= 1'b0;
      kind_r       <= '0;
      len_r        <= '0;
      rcrc_r       <= '0;
    end else if (item_pop) begin
      if (item.last) begin
        crc_r        <= crc16fc_pkg::CRC_INIT;
        magic_ok_r   <= 1'b0;
        version_ok_r <= 1'b0;
        kind_r       <= '0;
        len_r        <= '0;
        rcrc_r       <= '0;
      end else begin
        crc_r        <= crc_nxt;
        magic_ok_r   <= magic_ok_nxt;
        version_ok_r <= version_ok_nxt;
        kind_r       <= kind_nxt;
        len_r        <= len_nxt;
        rcrc_r       <= rcrc_nxt;
      end
    end
  end

  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_head  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (item_pop) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_take) begin
        oq_rd_r <= ~oq_rd_r;
      end
      if (item_pop && !oq_take) begin
        oq_cnt_r <= oq_cnt_r + 2'd1;
      end else if (oq_take && !item_pop) begin
        oq_cnt_r <= oq_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

/* src/crc16_frame_checker_unit.sv */
// top level of the crc16 frame checker
//
//  channel   ports                                   transfer when
//  -------   -------------------------------------   ---------------------------
//  input     in_push, in_full, in_data_byte,          in_push && !in_full
//            in_last_byte
//  result    out_pop, out_empty, out_payload_valid,   out_pop && !out_empty
//            out_payload_byte, out_frame_done,
//            out_status, out_message_type,
//            out_payload_length
//  config    cfg_valid, cfg_ready, cfg_index,         cfg_valid && cfg_ready
//            cfg_data
//
// one byte per cycle sustained while results are popped; a byte's result is
// registered first in the middle queue at its transfer edge, then in the
// result queue, whose head drives the result ports
// the crc of one byte is a single combinational step in the back end
// reset is synchronous, active low; it restores magic 0xa3, version 0x01 and an
// empty frame, and needs no clearing pass
// a stalled result side fills the two-entry result queue, then the four-entry
// middle queue, and only then raises in_full
module crc16_frame_checker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // byte input
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  // results
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic                              out_payload_valid,
  output logic [7:0]                        out_payload_byte,
  output logic                              out_frame_done,
  output logic [2:0]                        out_status,
  output logic [7:0]                        out_message_type,
  output logic [15:0]                       out_payload_length,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crc16fc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data
);

  logic [7:0] magic_r;
  logic [7:0] version_r;

  logic                 mq_push;
  logic                 mq_full;
  logic                 mq_pop;
  logic                 mq_empty;
  crc16fc_pkg::item_t   mq_din;
  crc16fc_pkg::item_t   mq_dout;
  crc16fc_pkg::result_t head;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= crc16fc_pkg::MAGIC_RST;
      version_r <= crc16fc_pkg::VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == crc16fc_pkg::CFG_MAGIC) begin
        magic_r <= cfg_data;
      end
      if (cfg_index == crc16fc_pkg::CFG_VERSION) begin
        version_r <= cfg_data;
      end
    end
  end

  // input is blocked only by the middle queue
  assign in_full = mq_full;

  crc16fc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .magic_value   (magic_r),
    .version_value (version_r),
    .q_full        (mq_full),
    .q_push        (mq_push),
    .q_item        (mq_din)
  );

  crc16fc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .din   (mq_din),
    .full  (mq_full),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .empty (mq_empty)
  );

  crc16fc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (~mq_empty),
    .item       (mq_dout),
    .item_pop   (mq_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_head   (head)
  );

  // head of the result queue onto the ports
  assign out_payload_valid  = head.payload_valid;
  assign out_payload_byte   = head.payload_byte;
  assign out_frame_done     = head.frame_done;
  assign out_status         = head.status;
  assign out_message_type   = head.message_type;
  assign out_payload_length = head.payload_length;

endmodule

/* bench/tb_crc16_frame_checker_unit.sv */
// testbench for crc16_frame_checker_unit: directed and random frames checked byte by byte
module tb_crc16_frame_checker_unit;

  // run limit in clock cycles, several times the slowest legal run
  localparam int CYCLE_LIMIT = 2_000_000;
  // cycles the result side stays stalled when a long hold-off is requested
  localparam int HOLD_CYCLES = 300;
  // least number of input bytes per random phase, four phases
  localparam int PHASE_ITEMS = 375;
  // register indexes with no register behind them
  localparam logic [crc16fc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2;
  localparam logic [crc16fc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  typedef enum int {
    FR_GOOD,
    FR_SHORT,
    FR_BAD_MAGIC,
    FR_BAD_VERSION,
    FR_BAD_LENGTH,
    FR_BAD_CRC,
    FR_NOISE
  } frame_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
  } frame_byte_t;

  typedef logic [7:0] byte_list_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_push = 1'b0;
  logic                              in_full;
  logic [7:0]                        in_data_byte = 8'h00;
  logic                              in_last_byte = 1'b0;
  logic                              out_pop = 1'b0;
  logic                              out_empty;
  logic                              out_payload_valid;
  logic [7:0]                        out_payload_byte;
  logic                              out_frame_done;
  logic [2:0]                        out_status;
  logic [7:0]                        out_message_type;
  logic [15:0]                       out_payload_length;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [crc16fc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                        cfg_data = 8'h00;

  crc16_frame_checker_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_frame_done     (out_frame_done),
    .out_status         (out_status),
    .out_message_type   (out_message_type),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bytes waiting to be offered, and results predicted but not yet popped
  frame_byte_t          byte_queue[$];
  crc16fc_pkg::result_t expected_results[$];

  // register copies, written only by the stimulus process on a cfg transfer
  logic [7:0] magic_cfg = crc16fc_pkg::MAGIC_RST;
  logic [7:0] version_cfg = crc16fc_pkg::VERSION_RST;

  // frame state of the predictor, owned by the driver process
  logic [crc16fc_pkg::COUNT_W-1:0] rx_count = '0;
  logic [15:0]                     rx_crc = crc16fc_pkg::CRC_INIT;
  logic                            rx_magic_ok = 1'b0;
  logic                            rx_version_ok = 1'b0;
  logic [7:0]                      rx_kind = 8'h00;
  logic [15:0]                     rx_len = 16'h0000;
  logic [15:0]                     rx_crc_field = 16'h0000;

  int  fail_count = 0;
  int  bytes_queued = 0;
  int  cycle_count = 0;
  int  hold_asked = 0;     // long result stalls requested ...
  int  hold_served = 0;    // ... and started
  int  hold_left = 0;

  // reflected crc16, one input bit per step
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      if (acc[0] ^ b[k]) acc = (acc >> 1) ^ crc16fc_pkg::CRC_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  function automatic void clear_frame();
    rx_count = '0;
    rx_crc = crc16fc_pkg::CRC_INIT;
    rx_magic_ok = 1'b0;
    rx_version_ok = 1'b0;
    rx_kind = 8'h00;
    rx_len = 16'h0000;
    rx_crc_field = 16'h0000;
  endfunction

  // expected result of one accepted byte; advances the frame state
  function automatic crc16fc_pkg::result_t predict_byte(input logic [7:0] b, input logic last);
    crc16fc_pkg::result_t            res;
    crc16fc_pkg::field_t             fld;
    logic [crc16fc_pkg::COUNT_W-1:0] total;
    crc16fc_pkg::status_t            st;
    res = '0;
    if (rx_count < crc16fc_pkg::HDR_COUNT) fld = crc16fc_pkg::field_t'(rx_count[3:0]);
    else fld = crc16fc_pkg::FLD_PAYLOAD;
    case (fld)
      crc16fc_pkg::FLD_MAGIC:   rx_magic_ok = (b == magic_cfg);
      crc16fc_pkg::FLD_VERSION: rx_version_ok = (b == version_cfg);
      crc16fc_pkg::FLD_KIND:    rx_kind = b;
      crc16fc_pkg::FLD_LEN_LO:  rx_len[7:0] = b;
      crc16fc_pkg::FLD_LEN_HI:  rx_len[15:8] = b;
      crc16fc_pkg::FLD_CRC_LO:  rx_crc_field[7:0] = b;
      crc16fc_pkg::FLD_CRC_HI:  rx_crc_field[15:8] = b;
      default: ;
    endcase
    // the stored crc bytes are left out of the running crc
    if (fld != crc16fc_pkg::FLD_CRC_LO && fld != crc16fc_pkg::FLD_CRC_HI) begin
      rx_crc = crc16_step(rx_crc, b);
    end
    // byte count saturates, later bytes still count as payload
    total = (rx_count == crc16fc_pkg::COUNT_MAX) ? crc16fc_pkg::COUNT_MAX : rx_count + 1'b1;
    rx_count = total;
    res.payload_valid = (fld == crc16fc_pkg::FLD_PAYLOAD);
    res.payload_byte = res.payload_valid ? b : 8'h00;
    res.frame_done = last;
    res.status = crc16fc_pkg::ST_OK;
    if (last) begin
      // first failing check wins
      if (total < crc16fc_pkg::HDR_COUNT) st = crc16fc_pkg::ST_SHORT;
      else if (!rx_magic_ok) st = crc16fc_pkg::ST_BAD_MAGIC;
      else if (!rx_version_ok) st = crc16fc_pkg::ST_BAD_VERSION;
      else if (crc16fc_pkg::HDR_COUNT + {1'b0, rx_len} != total) st = crc16fc_pkg::ST_LEN_MISMATCH;
      else if (rx_crc != rx_crc_field) st = crc16fc_pkg::ST_CRC_MISMATCH;
      else st = crc16fc_pkg::ST_OK;
      res.status = st;
      if (st != crc16fc_pkg::ST_SHORT) res.payload_length = rx_len;
      if (st == crc16fc_pkg::ST_OK) res.message_type = rx_kind;
      clear_frame();
    end
    return res;
  endfunction

  function automatic int field_mismatch(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] got);
    if (got === exp_val) return 0;
    $error("%s: expected %0d, got %0d", name, exp_val, got);
    return 1;
  endfunction

  // driver: offers the head of byte_queue after its gap, predicts on transfer
  int tx_wait = 0;
  bit offering = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      offering = 1'b0;
      tx_wait = 0;
      clear_frame();
    end else begin
      if (in_push && !in_full) begin
        expected_results.push_back(predict_byte(in_data_byte, in_last_byte));
        void'(byte_queue.pop_front());
        offering = 1'b0;
        tx_wait = 0;
      end
      if (!offering && byte_queue.size() != 0) begin
        if (tx_wait >= byte_queue[0].gap) offering = 1'b1;
        else tx_wait++;
      end
      // push stays high across back-to-back transfers, one assignment per edge
      in_push <= offering;
      if (offering) begin
        in_data_byte <= byte_queue[0].data;
        in_last_byte <= byte_queue[0].last;
      end
    end
  end

  // long result stall, timed in its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  // monitor: pops after a drawn number of cycles with a result waiting
  int                   rx_wait = 0;
  int                   rx_gap = 0;
  bit                   rx_burst = 1'b0;
  crc16fc_pkg::result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      rx_wait = 0;
      rx_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          fail_count += field_mismatch("payload_valid", 16'(want.payload_valid),
                                       16'(out_payload_valid));
          fail_count += field_mismatch("payload_byte", 16'(want.payload_byte),
                                       16'(out_payload_byte));
          fail_count += field_mismatch("frame_done", 16'(want.frame_done),
                                       16'(out_frame_done));
          fail_count += field_mismatch("status", 16'(want.status), 16'(out_status));
          fail_count += field_mismatch("message_type", 16'(want.message_type),
                                       16'(out_message_type));
          fail_count += field_mismatch("payload_length", want.payload_length,
                                       out_payload_length);
        end
        // now and then switch between gapped and gapless stretches
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = 0;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 10);
      end else if (!out_empty && rx_wait < rx_gap) begin
        rx_wait++;
      end
      out_pop <= (hold_left == 0) && (rx_wait >= rx_gap);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one register write; valid is lowered again before the task returns, so it never drops and rises in one step
  task automatic write_reg(input logic [crc16fc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == crc16fc_pkg::CFG_MAGIC) magic_cfg = val;
    else if (idx == crc16fc_pkg::CFG_VERSION) version_cfg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pauses until every byte is through and every result popped
  task automatic wait_idle();
    while (byte_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // frame bytes: header with the given magic and version, then n payload bytes (short, noise: random bytes)
  task automatic build_frame(input frame_kind_t kind, input int n, input logic [7:0] mtype,
                             input logic [15:0] len_field, input logic [7:0] mg,
                             input logic [7:0] vr, output byte_list_t fb);
    logic [7:0]  pay[$];
    logic [7:0]  hdr[6];
    logic [15:0] crc;
    fb = {};
    if (kind == FR_SHORT || kind == FR_NOISE) begin
      // short frames open with the right magic so only the length can fail
      n = (kind == FR_SHORT) ? $urandom_range(1, 7) : $urandom_range(1, 24);
      for (int k = 0; k < n; k++) fb.push_back(8'($urandom));
      if (kind == FR_SHORT) fb[0] = mg;
    end else begin
      for (int k = 0; k < n; k++) pay.push_back(8'($urandom));
      hdr[0] = (kind == FR_BAD_MAGIC) ? mg ^ 8'($urandom_range(1, 255)) : mg;
      hdr[1] = (kind == FR_BAD_VERSION) ? vr ^ 8'($urandom_range(1, 255)) : vr;
      hdr[2] = mtype;
      hdr[3] = 8'($urandom);
      hdr[4] = len_field[7:0];
      hdr[5] = len_field[15:8];
      crc = crc16fc_pkg::CRC_INIT;
      foreach (hdr[k]) crc = crc16_step(crc, hdr[k]);
      foreach (pay[k]) crc = crc16_step(crc, pay[k]);
      if (kind == FR_BAD_CRC) crc ^= 16'($urandom_range(1, 65535));
      foreach (hdr[k]) fb.push_back(hdr[k]);
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
      foreach (pay[k]) fb.push_back(pay[k]);
    end
  endtask

  // queue bytes lo..hi-1 of a frame; the frame's final byte carries the mark
  task automatic push_bytes(input byte_list_t fb, input int lo, input int hi, input bit dense);
    frame_byte_t item;
    for (int k = lo; k < hi; k++) begin
      item.data = fb[k];
      item.last = (k == fb.size() - 1);
      item.gap = (dense || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      byte_queue.push_back(item);
      bytes_queued++;
    end
  endtask

  // one frame of the given kind with random content
  task automatic queue_frame(input frame_kind_t kind, input bit dense);
    byte_list_t  fb;
    int          n;
    int          delta;
    logic [15:0] len_field;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
    len_field = 16'(n);
    if (kind == FR_BAD_LENGTH) begin
      // either a near miss, including bytes past the declared length, or anything
      if ($urandom_range(0, 1) == 0) begin
        delta = $urandom_range(1, 3);
        len_field = ($urandom_range(0, 1) == 0) ? 16'(n + delta) : 16'(n - delta);
      end else begin
        len_field = 16'(n) + 16'($urandom_range(1, 65535));
      end
    end
    build_frame(kind, n, 8'($urandom), len_field, magic_cfg, version_cfg, fb);
    push_bytes(fb, 0, fb.size(), dense);
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FR_GOOD;
    if (r < 62) return FR_SHORT;
    if (r < 69) return FR_BAD_MAGIC;
    if (r < 76) return FR_BAD_VERSION;
    if (r < 84) return FR_BAD_LENGTH;
    if (r < 92) return FR_BAD_CRC;
    return FR_NOISE;
  endfunction

  initial begin
    byte_list_t fb;
    int         phase_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-byte frame, good frame with one payload byte and a zero type,
    // declared length at its maximum with an empty payload
    fb = {8'hFF};
    push_bytes(fb, 0, 1, 1'b0);
    build_frame(FR_GOOD, 1, 8'h00, 16'd1, magic_cfg, version_cfg, fb);
    push_bytes(fb, 0, fb.size(), 1'b0);
    build_frame(FR_GOOD, 0, 8'hFF, 16'hFFFF, magic_cfg, version_cfg, fb);
    push_bytes(fb, 0, fb.size(), 1'b1);
    wait_idle();

    // register writes in the middle of a frame: the magic byte was already
    // judged against the old value, the version byte uses the new one
    build_frame(FR_GOOD, 2, 8'h3C, 16'd2, magic_cfg, 8'h5A, fb);
    push_bytes(fb, 0, 1, 1'b0);
    wait_idle();
    write_reg(crc16fc_pkg::CFG_MAGIC, 8'h00);
    write_reg(crc16fc_pkg::CFG_VERSION, 8'h5A);
    // writes to unused indexes change nothing
    write_reg(CFG_UNUSED_LO, 8'hFF);
    write_reg(CFG_UNUSED_HI, 8'hFF);
    push_bytes(fb, 1, fb.size(), 1'b0);
    wait_idle();

    // random phases, each behind a new register setting
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(crc16fc_pkg::CFG_MAGIC, 8'h00);
          write_reg(crc16fc_pkg::CFG_VERSION, 8'h00);
        end
        1: begin
          write_reg(crc16fc_pkg::CFG_MAGIC, 8'hFF);
          write_reg(crc16fc_pkg::CFG_VERSION, 8'hFF);
        end
        2: begin
          write_reg(crc16fc_pkg::CFG_MAGIC, 8'($urandom));
          write_reg(crc16fc_pkg::CFG_VERSION, 8'($urandom));
        end
        default: begin
          write_reg(crc16fc_pkg::CFG_MAGIC, crc16fc_pkg::MAGIC_RST);
          write_reg(crc16fc_pkg::CFG_VERSION, crc16fc_pkg::VERSION_RST);
        end
      endcase
      if (phase == 1) begin
        // results stalled for a long stretch while bytes keep coming, so in_full rises
        hold_asked++;
        queue_frame(FR_GOOD, 1'b1);
        queue_frame(FR_BAD_CRC, 1'b1);
        queue_frame(FR_GOOD, 1'b1);
      end
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_ITEMS) begin
        queue_frame(pick_kind(), $urandom_range(0, 4) == 0);
      end
      wait_idle();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
